### rtl/vstg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the video sync timing generator.
// Depends on nothing; every other file of the block imports it.
package vstg_pkg;

  localparam int unsigned CNT_W    = 10;
  localparam int unsigned VAL_W    = 20;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned NUM_BITS = 10;
  localparam int unsigned PROD_W   = 2 * VAL_W;

  // Raster totals: pixels per line and lines per frame.
  localparam int unsigned H_TOTAL = 454;
  localparam int unsigned V_TOTAL = 262;

  // Reciprocals scaled by 2**VAL_W; a quotient estimate is exact or one short.
  localparam int unsigned DIV_S = VAL_W;
  localparam logic [VAL_W-1:0] RCP_H = VAL_W'((64'd1 << DIV_S) / H_TOTAL);
  localparam logic [VAL_W-1:0] RCP_V = VAL_W'((64'd1 << DIV_S) / V_TOTAL);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 3'd0,
    CMD_SET_POS   = 3'd1,
    CMD_SET_H     = 3'd2,
    CMD_SET_V     = 3'd3,
    CMD_SET_H_BIT = 3'd4,
    CMD_SET_V_BIT = 3'd5
  } vstg_cmd_t;

  localparam logic [CFG_AW-1:0] REG_HBLANK_BEGIN  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HBLANK_FINISH = 3'd1;
  localparam logic [CFG_AW-1:0] REG_HSYNC_BEGIN   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_HSYNC_FINISH  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_VBLANK_BEGIN  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_VBLANK_FINISH = 3'd5;
  localparam logic [CFG_AW-1:0] REG_VSYNC_BEGIN   = 3'd6;
  localparam logic [CFG_AW-1:0] REG_VSYNC_FINISH  = 3'd7;

  localparam logic [CNT_W-1:0] HBLANK_BEGIN_RST  = 10'd0;
  localparam logic [CNT_W-1:0] HBLANK_FINISH_RST = 10'd80;
  localparam logic [CNT_W-1:0] HSYNC_BEGIN_RST   = 10'd32;
  localparam logic [CNT_W-1:0] HSYNC_FINISH_RST  = 10'd64;
  localparam logic [CNT_W-1:0] VBLANK_BEGIN_RST  = 10'd0;
  localparam logic [CNT_W-1:0] VBLANK_FINISH_RST = 10'd16;
  localparam logic [CNT_W-1:0] VSYNC_BEGIN_RST   = 10'd4;
  localparam logic [CNT_W-1:0] VSYNC_FINISH_RST  = 10'd8;

  localparam logic [CNT_W-1:0] HFIN_MOD_RST = CNT_W'(80 % H_TOTAL);
  localparam logic [CNT_W-1:0] VFIN_MOD_RST = CNT_W'(16 % V_TOTAL);

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] bit_index;
  } vstg_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] h_pos;
    logic [CNT_W-1:0] v_pos;
    logic [CNT_W-1:0] x_pos;
    logic [CNT_W-1:0] y_pos;
    logic             in_hblank;
    logic             in_hsync;
    logic             in_vblank;
    logic             in_vsync;
  } vstg_out_t;

  // Command with the input value already reduced by the divider pipeline.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] bit_index;
    logic             bit_val;
    logic [CNT_W-1:0] h_mod;   // value mod H_TOTAL
    logic [CNT_W-1:0] v_mod;   // value mod V_TOTAL
    logic [CNT_W-1:0] pos_v;   // (value div H_TOTAL) mod V_TOTAL
  } vstg_pre_t;

  typedef struct packed {
    logic [CNT_W-1:0] hblank_begin;
    logic [CNT_W-1:0] hblank_finish;
    logic [CNT_W-1:0] hsync_begin;
    logic [CNT_W-1:0] hsync_finish;
    logic [CNT_W-1:0] vblank_begin;
    logic [CNT_W-1:0] vblank_finish;
    logic [CNT_W-1:0] vsync_begin;
    logic [CNT_W-1:0] vsync_finish;
    logic [CNT_W-1:0] hfin_mod;
    logic [CNT_W-1:0] vfin_mod;
  } vstg_cfg_t;

  typedef logic [NUM_BITS-1:0][CNT_W-1:0] bit_tab_t;

  // 2**k mod H_TOTAL.
  function automatic bit_tab_t h_rem_tab();
    bit_tab_t t;
    for (int k = 0; k < NUM_BITS; k++) t[k] = CNT_W'((1 << k) % H_TOTAL);
    return t;
  endfunction

  // (2**k div H_TOTAL) mod V_TOTAL: how many lines a set bit of h carries.
  function automatic bit_tab_t h_carry_tab();
    bit_tab_t t;
    for (int k = 0; k < NUM_BITS; k++) t[k] = CNT_W'(((1 << k) / H_TOTAL) % V_TOTAL);
    return t;
  endfunction

  // 2**k mod V_TOTAL.
  function automatic bit_tab_t v_rem_tab();
    bit_tab_t t;
    for (int k = 0; k < NUM_BITS; k++) t[k] = CNT_W'((1 << k) % V_TOTAL);
    return t;
  endfunction

  localparam bit_tab_t H_BIT_REM   = h_rem_tab();
  localparam bit_tab_t H_BIT_CARRY = h_carry_tab();
  localparam bit_tab_t V_BIT_REM   = v_rem_tab();

  // A window that does not run forward wraps; equal bounds mean always active.
  function automatic logic in_window(logic [CNT_W-1:0] c, logic [CNT_W-1:0] b,
                                     logic [CNT_W-1:0] e);
    if (b < e) begin
      in_window = (c >= b) && (c < e);
    end else begin
      in_window = (c >= b) || (c < e);
    end
  endfunction

endpackage

### rtl/vstg_cfg.sv
`timescale 1ns / 1ps
// Window register file of the timing generator, with the blank-end residues
// that the active position needs. Depends on vstg_pkg.
module vstg_cfg import vstg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  output vstg_cfg_t         cfg
);

  logic [CNT_W-1:0] hbb_r, hbf_r, hsb_r, hsf_r, vbb_r, vbf_r, vsb_r, vsf_r;
  logic [CNT_W-1:0] hfin_mod_r, vfin_mod_r;

  // Residue pipeline: reciprocal product, estimate, then one correction.
  logic [CNT_W+VAL_W-1:0] hp_r, vp_r;
  logic [CNT_W-1:0]       hd_r, vd_r;
  logic [CNT_W:0]         he_r, ve_r;
  logic [CNT_W-1:0]       hq, vq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hbb_r <= HBLANK_BEGIN_RST;
      hbf_r <= HBLANK_FINISH_RST;
      hsb_r <= HSYNC_BEGIN_RST;
      hsf_r <= HSYNC_FINISH_RST;
      vbb_r <= VBLANK_BEGIN_RST;
      vbf_r <= VBLANK_FINISH_RST;
      vsb_r <= VSYNC_BEGIN_RST;
      vsf_r <= VSYNC_FINISH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HBLANK_BEGIN:  hbb_r <= cfg_wdata;
        REG_HBLANK_FINISH: hbf_r <= cfg_wdata;
        REG_HSYNC_BEGIN:   hsb_r <= cfg_wdata;
        REG_HSYNC_FINISH:  hsf_r <= cfg_wdata;
        REG_VBLANK_BEGIN:  vbb_r <= cfg_wdata;
        REG_VBLANK_FINISH: vbf_r <= cfg_wdata;
        REG_VSYNC_BEGIN:   vsb_r <= cfg_wdata;
        REG_VSYNC_FINISH:  vsf_r <= cfg_wdata;
      endcase
    end
  end

  assign hq = hp_r[CNT_W+VAL_W-1:DIV_S];
  assign vq = vp_r[CNT_W+VAL_W-1:DIV_S];

  always_ff @(posedge clk) begin
    hp_r <= (CNT_W+VAL_W)'(hbf_r) * (CNT_W+VAL_W)'(RCP_H);
    vp_r <= (CNT_W+VAL_W)'(vbf_r) * (CNT_W+VAL_W)'(RCP_V);
    hd_r <= hbf_r;
    vd_r <= vbf_r;
    he_r <= (CNT_W+1)'(hd_r) - (CNT_W+1)'(hq) * (CNT_W+1)'(H_TOTAL);
    ve_r <= (CNT_W+1)'(vd_r) - (CNT_W+1)'(vq) * (CNT_W+1)'(V_TOTAL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hfin_mod_r <= HFIN_MOD_RST;
      vfin_mod_r <= VFIN_MOD_RST;
    end else begin
      hfin_mod_r <= (he_r >= (CNT_W+1)'(H_TOTAL)) ? CNT_W'(he_r - (CNT_W+1)'(H_TOTAL))
                                                  : CNT_W'(he_r);
      vfin_mod_r <= (ve_r >= (CNT_W+1)'(V_TOTAL)) ? CNT_W'(ve_r - (CNT_W+1)'(V_TOTAL))
                                                  : CNT_W'(ve_r);
    end
  end

  always_comb begin
    cfg.hblank_begin  = hbb_r;
    cfg.hblank_finish = hbf_r;
    cfg.hsync_begin   = hsb_r;
    cfg.hsync_finish  = hsf_r;
    cfg.vblank_begin  = vbb_r;
    cfg.vblank_finish = vbf_r;
    cfg.vsync_begin   = vsb_r;
    cfg.vsync_finish  = vsf_r;
    cfg.hfin_mod      = hfin_mod_r;
    cfg.vfin_mod      = vfin_mod_r;
  end

endmodule

### rtl/vstg_div.sv
`timescale 1ns / 1ps
// Five-stage pipeline that reduces the 20-bit input value by the raster totals
// with reciprocal multiplies. Depends on vstg_pkg.
module vstg_div import vstg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  vstg_in_t  up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output vstg_pre_t dn_item
);

  localparam int unsigned NST = 5;

  logic [NST-1:0] vld_r;
  logic [NST:0]   rdy;

  // Command fields ride along with each stage.
  logic [CMD_W-1:0] cmd_r [NST];
  logic [IDX_W-1:0] idx_r [NST];
  logic             bit_r [NST];

  logic [VAL_W-1:0]  a_val_r;
  logic [PROD_W-1:0] a_ph_r, a_pv_r;
  logic [VAL_W-1:0]  b_qh_r;
  logic [CNT_W:0]    b_rh_r, b_rv_r;
  logic [VAL_W-1:0]  c_qh_r;
  logic [PROD_W-1:0] c_pq_r;
  logic [CNT_W-1:0]  c_rh_r, c_rv_r;
  logic [CNT_W:0]    d_r2_r;
  logic [CNT_W-1:0]  d_rh_r, d_rv_r;
  logic [CNT_W-1:0]  e_rh_r, e_rv_r, e_r2_r;

  logic [VAL_W-1:0] qh_est, qv_est, qh_mul, qv_mul, qh_fix, q2_est, q2_mul;
  logic             rh_over;

  always_comb begin
    rdy[NST] = dn_ready;
    for (int k = NST - 1; k >= 0; k--) rdy[k] = !vld_r[k] || rdy[k+1];
  end

  assign up_ready = rdy[0];
  assign dn_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cmd_r[0] <= up_item.command;
      idx_r[0] <= up_item.bit_index;
      bit_r[0] <= up_item.value[0];
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) begin
        cmd_r[k] <= cmd_r[k-1];
        idx_r[k] <= idx_r[k-1];
        bit_r[k] <= bit_r[k-1];
      end
    end
  end

  assign qh_est  = a_ph_r[PROD_W-1:DIV_S];
  assign qv_est  = a_pv_r[PROD_W-1:DIV_S];
  assign qh_mul  = qh_est * VAL_W'(H_TOTAL);
  assign qv_mul  = qv_est * VAL_W'(V_TOTAL);
  assign rh_over = b_rh_r >= (CNT_W+1)'(H_TOTAL);
  assign qh_fix  = b_qh_r + VAL_W'(rh_over);
  assign q2_est  = c_pq_r[PROD_W-1:DIV_S];
  assign q2_mul  = q2_est * VAL_W'(V_TOTAL);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_val_r <= up_item.value;
      a_ph_r  <= PROD_W'(up_item.value) * PROD_W'(RCP_H);
      a_pv_r  <= PROD_W'(up_item.value) * PROD_W'(RCP_V);
    end
    if (rdy[1]) begin
      b_qh_r <= qh_est;
      b_rh_r <= (CNT_W+1)'(a_val_r - qh_mul);
      b_rv_r <= (CNT_W+1)'(a_val_r - qv_mul);
    end
    if (rdy[2]) begin
      c_qh_r <= qh_fix;
      c_pq_r <= PROD_W'(qh_fix) * PROD_W'(RCP_V);
      c_rh_r <= rh_over ? CNT_W'(b_rh_r - (CNT_W+1)'(H_TOTAL)) : CNT_W'(b_rh_r);
      c_rv_r <= (b_rv_r >= (CNT_W+1)'(V_TOTAL)) ? CNT_W'(b_rv_r - (CNT_W+1)'(V_TOTAL))
                                                : CNT_W'(b_rv_r);
    end
    if (rdy[3]) begin
      d_r2_r <= (CNT_W+1)'(c_qh_r - q2_mul);
      d_rh_r <= c_rh_r;
      d_rv_r <= c_rv_r;
    end
    if (rdy[4]) begin
      e_r2_r <= (d_r2_r >= (CNT_W+1)'(V_TOTAL)) ? CNT_W'(d_r2_r - (CNT_W+1)'(V_TOTAL))
                                                : CNT_W'(d_r2_r);
      e_rh_r <= d_rh_r;
      e_rv_r <= d_rv_r;
    end
  end

  always_comb begin
    dn_item.command   = cmd_r[NST-1];
    dn_item.bit_index = idx_r[NST-1];
    dn_item.bit_val   = bit_r[NST-1];
    dn_item.h_mod     = e_rh_r;
    dn_item.v_mod     = e_rv_r;
    dn_item.pos_v     = e_r2_r;
  end

endmodule

### rtl/video_sync_timing_generator_unit.sv
`timescale 1ns / 1ps
// Top level of the raster timing generator: counters, windows and output register.
// Depends on vstg_pkg, vstg_cfg and vstg_div.
//
// Usage: each item on the in_ channel is one command (pixel tick, load the
// linear position, load h or v, or replace one bit of h or v). Every item
// returns exactly one item on the out_ channel with the counters after the
// command, the active column and line, and the four window flags.
// Both channels use valid/ready; an item moves on a clock edge where both
// are high. The cfg_ port writes one of the eight window registers per
// write. The user must ensure it is used only while no item is in flight; the
// block itself does not enforce this. Throughput is one item per cycle while the
// receiver keeps taking results: the value reduction is a five-stage
// reciprocal-multiply pipeline and the counter update is an add, compare and
// select into the counter registers, so a new item enters on every clock.
// After reset (synchronous, rst_n low) the counters are zero, the window
// registers hold their defaults and the pipeline is empty. A write to the
// blank-end registers passes through the product, estimate and correction
// registers to the active-position residue before any later item needs it.
// When the receiver stalls, the output register holds its item and the
// stages behind it fill up; in_ready drops only once every stage is full.
module video_sync_timing_generator_unit import vstg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vstg_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vstg_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  vstg_cfg_t cfg;
  vstg_pre_t pre;
  logic      pre_valid, pre_ready;

  vstg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vstg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_data),
    .dn_valid (pre_valid),
    .dn_ready (pre_ready),
    .dn_item  (pre)
  );

  // The counters are the architectural state and also the payload of the
  // counter stage: they change only when an item enters that stage.
  logic [CNT_W-1:0] h_r, v_r, h_nxt, v_nxt;
  logic             st_vld_r;
  logic             st_load, out_en;
  vstg_out_t        out_r, out_nxt;
  logic             out_valid_r;

  assign out_en    = !out_valid_r || out_ready;
  assign pre_ready = !st_vld_r || out_en;
  assign st_load   = pre_ready && pre_valid;

  // Bit replacement. Clearing a bit only lowers the counter. Setting a clear bit
  // adds 2**k: a per-bit remainder (and, for h, a line carry into v), so that
  // each wrap is a single compare and subtract.
  logic             idx_ok;
  logic [IDX_W-1:0] idx_sel;
  logic [CNT_W-1:0] mask;
  logic [CNT_W:0]   hs, hv, vs;
  logic             h_carry;
  logic [CNT_W-1:0] h_bit_h, h_bit_v, v_bit_v;
  logic             h_last, v_last;

  always_comb begin
    idx_ok  = pre.bit_index <= IDX_W'(NUM_BITS - 1);
    idx_sel = idx_ok ? pre.bit_index : '0;
    mask    = idx_ok ? (CNT_W'(1) << idx_sel) : '0;

    hs      = (CNT_W+1)'(h_r) + (CNT_W+1)'(H_BIT_REM[idx_sel]);
    h_carry = hs >= (CNT_W+1)'(H_TOTAL);
    h_bit_h = h_carry ? CNT_W'(hs - (CNT_W+1)'(H_TOTAL)) : CNT_W'(hs);
    hv      = (CNT_W+1)'(v_r) + (CNT_W+1)'(H_BIT_CARRY[idx_sel]) + (CNT_W+1)'(h_carry);
    h_bit_v = (hv >= (CNT_W+1)'(V_TOTAL)) ? CNT_W'(hv - (CNT_W+1)'(V_TOTAL)) : CNT_W'(hv);

    vs      = (CNT_W+1)'(v_r) + (CNT_W+1)'(V_BIT_REM[idx_sel]);
    v_bit_v = (vs >= (CNT_W+1)'(V_TOTAL)) ? CNT_W'(vs - (CNT_W+1)'(V_TOTAL)) : CNT_W'(vs);

    h_last  = h_r == CNT_W'(H_TOTAL - 1);
    v_last  = v_r == CNT_W'(V_TOTAL - 1);
  end

  always_comb begin
    h_nxt = h_r;
    v_nxt = v_r;
    unique case (pre.command)
      CMD_TICK: begin
        if (h_last) begin
          h_nxt = '0;
          v_nxt = v_last ? '0 : v_r + CNT_W'(1);
        end else begin
          h_nxt = h_r + CNT_W'(1);
        end
      end
      CMD_SET_POS: begin
        h_nxt = pre.h_mod;
        v_nxt = pre.pos_v;
      end
      CMD_SET_H: h_nxt = pre.h_mod;
      CMD_SET_V: v_nxt = pre.v_mod;
      CMD_SET_H_BIT: begin
        if (idx_ok) begin
          if (!pre.bit_val) begin
            h_nxt = h_r & ~mask;
          end else if ((h_r & mask) == '0) begin
            h_nxt = h_bit_h;
            v_nxt = h_bit_v;
          end
        end
      end
      CMD_SET_V_BIT: begin
        if (idx_ok) begin
          if (!pre.bit_val) begin
            v_nxt = v_r & ~mask;
          end else if ((v_r & mask) == '0) begin
            v_nxt = v_bit_v;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r      <= '0;
      v_r      <= '0;
      st_vld_r <= 1'b0;
    end else begin
      if (pre_ready) st_vld_r <= pre_valid;
      if (st_load) begin
        h_r <= h_nxt;
        v_r <= v_nxt;
      end
    end
  end

  // Status from the counters held in the counter stage. Outside blanking the active position
  // is the distance from the blank end around the raster total, or zero in blanking.
  logic hb, vb;

  always_comb begin
    hb = in_window(h_r, cfg.hblank_begin, cfg.hblank_finish);
    vb = in_window(v_r, cfg.vblank_begin, cfg.vblank_finish);
    out_nxt.h_pos     = h_r;
    out_nxt.v_pos     = v_r;
    out_nxt.in_hblank = hb;
    out_nxt.in_vblank = vb;
    out_nxt.in_hsync  = in_window(h_r, cfg.hsync_begin, cfg.hsync_finish);
    out_nxt.in_vsync  = in_window(v_r, cfg.vsync_begin, cfg.vsync_finish);
    if (hb) begin
      out_nxt.x_pos = '0;
    end else if (h_r >= cfg.hfin_mod) begin
      out_nxt.x_pos = h_r - cfg.hfin_mod;
    end else begin
      out_nxt.x_pos = CNT_W'((CNT_W+1)'(h_r) + (CNT_W+1)'(H_TOTAL) - (CNT_W+1)'(cfg.hfin_mod));
    end
    if (vb) begin
      out_nxt.y_pos = '0;
    end else if (v_r >= cfg.vfin_mod) begin
      out_nxt.y_pos = v_r - cfg.vfin_mod;
    end else begin
      out_nxt.y_pos = CNT_W'((CNT_W+1)'(v_r) + (CNT_W+1)'(V_TOTAL) - (CNT_W+1)'(cfg.vfin_mod));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= st_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && st_vld_r) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/vstg_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the timing generator, attached by bind.
// Depends on vstg_pkg and video_sync_timing_generator_unit.
module vstg_checker import vstg_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input vstg_out_t out_data
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The counters never leave the raster.
  a_in_raster: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.h_pos <= CNT_W'(H_TOTAL - 1)) &&
                  (out_data.v_pos <= CNT_W'(V_TOTAL - 1)))
    else $error("counter beyond raster total");

  // Blanking forces the active column to zero.
  a_hblank_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_hblank |-> out_data.x_pos == '0)
    else $error("active column nonzero in horizontal blanking");

  // Blanking forces the active line to zero.
  a_vblank_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_vblank |-> out_data.y_pos == '0)
    else $error("active line nonzero in vertical blanking");

endmodule

bind video_sync_timing_generator_unit vstg_checker u_vstg_checker (.*);

### dv/video_sync_timing_generator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for video_sync_timing_generator_unit: raster counters and windows.
// Depends on vstg_pkg and the RTL of the block; it needs no other file.
module video_sync_timing_generator_unit_test;
  import vstg_pkg::*;

  // The two command codes that the package leaves unnamed; the block must
  // ignore them and still report its status.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam int unsigned FRAME_SIZE    = H_TOTAL * V_TOTAL;
  localparam int unsigned NUM_WINDOWS   = 8;
  localparam int unsigned NUM_PHASES    = 7;
  localparam int unsigned PHASE_ITEMS   = 182;
  // Idle clocks after draining, so that the pipeline is empty before a register write.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  vstg_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  vstg_out_t out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CNT_W-1:0]  cfg_wdata = '0;

  video_sync_timing_generator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Commands waiting to be offered, and the status items the raster
  // predictor says the block owes us, oldest first.
  vstg_in_t  command_backlog [$];
  vstg_out_t raster_expected [$];

  // Predictor state: both counters and its own copy of the window registers.
  int unsigned      raster_h;
  int unsigned      raster_v;
  logic [CNT_W-1:0] window_reg [NUM_WINDOWS];

  // Window bounds of the current phase, used to aim counter loads at edges.
  int unsigned phase_cfg [NUM_WINDOWS];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_took = 1'b0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------
  // Raster predictor
  // ---------------------------------------------------------------------

  // A window that does not run forward wraps around; equal bounds therefore
  // mean the window is always open.
  function automatic bit window_hit(int unsigned c, int unsigned b, int unsigned e);
    if (b < e) return (c >= b) && (c < e);
    return (c >= b) || (c < e);
  endfunction

  function automatic void split_linear(input int unsigned lin, output int unsigned h,
                                       output int unsigned v);
    lin = lin % FRAME_SIZE;
    h = lin % H_TOTAL;
    v = lin / H_TOTAL;
  endfunction

  // Applies one command to the predicted counters and returns the status
  // item that the block must report for it.
  function automatic vstg_out_t step_raster(vstg_in_t item);
    int unsigned h;
    int unsigned v;
    int unsigned mask;
    bit          hb;
    bit          vb;
    vstg_out_t   r;
    h = raster_h;
    v = raster_v;
    mask = 1 << item.bit_index;
    case (item.command)
      CMD_TICK: begin
        h++;
        if (h >= H_TOTAL) begin
          h = 0;
          v++;
          if (v >= V_TOTAL) v = 0;
        end
      end
      CMD_SET_POS: split_linear(item.value, h, v);
      CMD_SET_H: h = item.value % H_TOTAL;
      CMD_SET_V: v = item.value % V_TOTAL;
      // A replaced bit may push h past the line length or v past the frame;
      // the linear position then carries or wraps.
      CMD_SET_H_BIT: begin
        if (item.bit_index < NUM_BITS) begin
          h = item.value[0] ? (h | mask) : (h & ~mask);
          split_linear(v * H_TOTAL + h, h, v);
        end
      end
      CMD_SET_V_BIT: begin
        if (item.bit_index < NUM_BITS) begin
          v = item.value[0] ? (v | mask) : (v & ~mask);
          split_linear(v * H_TOTAL + h, h, v);
        end
      end
      default: ;
    endcase
    raster_h = h;
    raster_v = v;

    hb = window_hit(h, window_reg[REG_HBLANK_BEGIN], window_reg[REG_HBLANK_FINISH]);
    vb = window_hit(v, window_reg[REG_VBLANK_BEGIN], window_reg[REG_VBLANK_FINISH]);
    r.h_pos = CNT_W'(h);
    r.v_pos = CNT_W'(v);
    r.x_pos = hb ? '0 :
              CNT_W'((h + H_TOTAL - window_reg[REG_HBLANK_FINISH] % H_TOTAL) % H_TOTAL);
    r.y_pos = vb ? '0 :
              CNT_W'((v + V_TOTAL - window_reg[REG_VBLANK_FINISH] % V_TOTAL) % V_TOTAL);
    r.in_hblank = hb;
    r.in_hsync  = window_hit(h, window_reg[REG_HSYNC_BEGIN], window_reg[REG_HSYNC_FINISH]);
    r.in_vblank = vb;
    r.in_vsync  = window_hit(v, window_reg[REG_VSYNC_BEGIN], window_reg[REG_VSYNC_FINISH]);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic vstg_in_t make_command(logic [CMD_W-1:0] cmd, int unsigned val,
                                            int unsigned idx);
    vstg_in_t it;
    it.command   = cmd;
    it.value     = VAL_W'(val);
    it.bit_index = IDX_W'(idx);
    return it;
  endfunction

  // Counter loads are steered toward the end of the line or frame and
  // toward the window edges of the current phase, where the logic turns.
  function automatic logic [VAL_W-1:0] near_value(logic [VAL_W-1:0] noise, int unsigned pick,
                                                  int unsigned total, int unsigned bound);
    case (pick)
      1: return VAL_W'(total - 1 - $urandom_range(2));
      2: return VAL_W'(bound + $urandom_range(2) - 1);
      3: return VAL_W'($urandom_range(1023));
      default: return noise;
    endcase
  endfunction

  function automatic vstg_in_t random_command();
    vstg_in_t    it;
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(99);
    pick = $urandom_range(3);
    it.value = VAL_W'($urandom);
    it.bit_index = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(15, 10)) :
                                              IDX_W'($urandom_range(9));
    if (roll < 48) begin
      // Ticks dominate so that the counters sweep across whole lines.
      it.command = CMD_TICK;
      it.bit_index = IDX_W'($urandom_range(15));
    end else if (roll < 60) begin
      it.command = CMD_SET_POS;
      if (pick == 1) it.value = VAL_W'(FRAME_SIZE - 3 + $urandom_range(5));
      else if (pick == 2)
        it.value = VAL_W'($urandom_range(V_TOTAL - 1) * H_TOTAL + H_TOTAL - 1 - $urandom_range(3));
    end else if (roll < 69) begin
      it.command = CMD_SET_H;
      it.value = near_value(it.value, pick, H_TOTAL,
                            phase_cfg[REG_HBLANK_BEGIN + $urandom_range(3)]);
    end else if (roll < 78) begin
      it.command = CMD_SET_V;
      it.value = near_value(it.value, pick, V_TOTAL,
                            phase_cfg[REG_VBLANK_BEGIN + $urandom_range(3)]);
    end else if (roll < 88) begin
      it.command = CMD_SET_H_BIT;
    end else if (roll < 98) begin
      it.command = CMD_SET_V_BIT;
    end else begin
      it.command = $urandom_range(1) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
    end
    return it;
  endfunction

  function automatic int unsigned rand_bound(int unsigned total);
    return ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(total);
  endfunction

  // Writes all eight window registers, one per cycle, in index order.
  task automatic set_windows(int unsigned hbb, int unsigned hbf, int unsigned hsb,
                             int unsigned hsf, int unsigned vbb, int unsigned vbf,
                             int unsigned vsb, int unsigned vsf);
    phase_cfg[REG_HBLANK_BEGIN]  = hbb;
    phase_cfg[REG_HBLANK_FINISH] = hbf;
    phase_cfg[REG_HSYNC_BEGIN]   = hsb;
    phase_cfg[REG_HSYNC_FINISH]  = hsf;
    phase_cfg[REG_VBLANK_BEGIN]  = vbb;
    phase_cfg[REG_VBLANK_FINISH] = vbf;
    phase_cfg[REG_VSYNC_BEGIN]   = vsb;
    phase_cfg[REG_VSYNC_FINISH]  = vsf;
    for (int i = 0; i < NUM_WINDOWS; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_AW'(i);
      cfg_wdata <= CNT_W'(phase_cfg[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_random_windows();
    set_windows(rand_bound(H_TOTAL), rand_bound(H_TOTAL), rand_bound(H_TOTAL),
                rand_bound(H_TOTAL), rand_bound(V_TOTAL), rand_bound(V_TOTAL),
                rand_bound(V_TOTAL), rand_bound(V_TOTAL));
  endtask

  // Waits until every queued command has been taken and answered, then lets
  // the pipeline settle so the block is idle for a register write.
  task automatic drain_raster();
    while (command_backlog.size() != 0 || in_valid || raster_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers the backlog one item at a time on the falling edge.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      // A pending item stays up, unchanged, until the rising edge takes it.
      if (!in_valid || in_took) begin
        if (command_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= command_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: samples both channels and the register port on the rising edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    vstg_out_t want;
    if (!rst_n) begin
      raster_h = 0;
      raster_v = 0;
      window_reg[REG_HBLANK_BEGIN]  = HBLANK_BEGIN_RST;
      window_reg[REG_HBLANK_FINISH] = HBLANK_FINISH_RST;
      window_reg[REG_HSYNC_BEGIN]   = HSYNC_BEGIN_RST;
      window_reg[REG_HSYNC_FINISH]  = HSYNC_FINISH_RST;
      window_reg[REG_VBLANK_BEGIN]  = VBLANK_BEGIN_RST;
      window_reg[REG_VBLANK_FINISH] = VBLANK_FINISH_RST;
      window_reg[REG_VSYNC_BEGIN]   = VSYNC_BEGIN_RST;
      window_reg[REG_VSYNC_FINISH]  = VSYNC_FINISH_RST;
      in_took = 1'b0;
    end else begin
      if (cfg_we) window_reg[cfg_index] = cfg_wdata;

      in_took = in_valid && in_ready;
      if (in_took) begin
        raster_expected.push_back(step_raster(in_data));
        items_sent++;
      end

      if (out_valid && out_ready) begin
        if (raster_expected.size() == 0) begin
          $error("status item with none outstanding: h_pos %0d v_pos %0d",
                 out_data.h_pos, out_data.v_pos);
          mismatches++;
        end else begin
          want = raster_expected.pop_front();
          compare_field("h_pos", want.h_pos, out_data.h_pos);
          compare_field("v_pos", want.v_pos, out_data.v_pos);
          compare_field("x_pos", want.x_pos, out_data.x_pos);
          compare_field("y_pos", want.y_pos, out_data.y_pos);
          compare_field("in_hblank", want.in_hblank, out_data.in_hblank);
          compare_field("in_hsync", want.in_hsync, out_data.in_hsync);
          compare_field("in_vblank", want.in_vblank, out_data.in_vblank);
          compare_field("in_vsync", want.in_vsync, out_data.in_vsync);
          results_checked++;
        end
      end
    end
  end

  // A hung handshake must not hang the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass under the reset window settings and without idling:
    // line and frame wrap, loads at and past their ranges, bit replaces
    // that carry into v or wrap the frame, out-of-range bit indexes and the
    // two unused commands.
    command_backlog.push_back(make_command(CMD_TICK, 0, 0));
    command_backlog.push_back(make_command(CMD_SET_H, H_TOTAL - 1, 0));
    command_backlog.push_back(make_command(CMD_TICK, 0, 0));
    command_backlog.push_back(make_command(CMD_SET_V, V_TOTAL - 1, 0));
    command_backlog.push_back(make_command(CMD_SET_H, H_TOTAL - 1, 0));
    command_backlog.push_back(make_command(CMD_TICK, 0, 0));
    command_backlog.push_back(make_command(CMD_SET_POS, 20'hFFFFF, 0));
    command_backlog.push_back(make_command(CMD_SET_POS, FRAME_SIZE - 1, 0));
    command_backlog.push_back(make_command(CMD_SET_POS, FRAME_SIZE, 0));
    command_backlog.push_back(make_command(CMD_SET_H, 20'hFFFFF, 0));
    command_backlog.push_back(make_command(CMD_SET_V, 20'hFFFFF, 0));
    command_backlog.push_back(make_command(CMD_SET_H, 0, 0));
    command_backlog.push_back(make_command(CMD_SET_H_BIT, 1, 9));
    command_backlog.push_back(make_command(CMD_SET_V, 200, 0));
    command_backlog.push_back(make_command(CMD_SET_V_BIT, 1, 8));
    command_backlog.push_back(make_command(CMD_SET_H_BIT, 20'hFFFFE, 0));
    command_backlog.push_back(make_command(CMD_SET_V_BIT, 0, 9));
    command_backlog.push_back(make_command(CMD_SET_H_BIT, 1, 15));
    command_backlog.push_back(make_command(CMD_SET_V_BIT, 1, 10));
    command_backlog.push_back(make_command(CMD_UNUSED_LO, 0, 0));
    command_backlog.push_back(make_command(CMD_UNUSED_HI, 20'hFFFFF, 15));
    command_backlog.push_back(make_command(CMD_SET_V, V_TOTAL - 1, 0));
    command_backlog.push_back(make_command(CMD_SET_H_BIT, 1, 9));
    command_backlog.push_back(make_command(CMD_SET_POS, 0, 0));
    drain_raster();

    // Random phases. Each one writes a fresh set of windows while the block
    // is idle, then runs under one of four idling mixes in turn.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        // Ordinary windows, sync straddling the end of the frame.
        0: set_windows(440, 20, 400, 430, 250, 10, 255, 3);
        // Blanking never open, sync always open, bounds at the field limits.
        1: set_windows(1023, 0, 0, 1023, 1023, 0, 0, 1023);
        // Equal bounds everywhere: every window always open.
        3: set_windows(0, 0, 1023, 1023, 0, 0, 1023, 1023);
        6: set_windows(HBLANK_BEGIN_RST, HBLANK_FINISH_RST, HSYNC_BEGIN_RST,
                       HSYNC_FINISH_RST, VBLANK_BEGIN_RST, VBLANK_FINISH_RST,
                       VSYNC_BEGIN_RST, VSYNC_FINISH_RST);
        default: set_random_windows();
      endcase
      case (p % 4)
        1: begin send_idle_pct = 75; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 75; end
        3: begin send_idle_pct = 16; recv_stall_pct = 16; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (PHASE_ITEMS) command_backlog.push_back(random_command());
      drain_raster();
    end

    $display("Sent %0d commands over %0d window settings and four idle mixes.",
             items_sent, NUM_PHASES + 1);
    $display("Compared %0d status items field by field, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
